// ----- rtl/core/coverage_weighted_splat_blend_macros.svh -----
// assertion macros for the coverage weighted splat blend checker
// depends on nothing; taken in by the checker file only
`ifndef COVERAGE_WEIGHTED_SPLAT_BLEND_MACROS_SVH
`define COVERAGE_WEIGHTED_SPLAT_BLEND_MACROS_SVH

// generic clocked property with reset gating
`define CSBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition implies expectation in the same cycle
`define CSBD_ASSERT_NOW(label, clk, rst, cond, expect_now, msg) \
   `CSBD_ASSERT(label, clk, rst, (cond) |-> (expect_now), msg)

// condition implies expectation in the next cycle
`define CSBD_ASSERT_NEXT(label, clk, rst, cond, expect_next, msg) \
   `CSBD_ASSERT(label, clk, rst, (cond) |=> (expect_next), msg)

`endif

// ----- rtl/core/csbd_pkg.sv -----
// shared types and constants for the coverage weighted splat blend
// depends on nothing
package csbd_pkg;

   // store geometry
   localparam int unsigned PIXEL_COUNT_DEF = 65536;
   localparam int unsigned INDEX_SPAN      = 65536;
   localparam int unsigned INDEX_W         = 16;
   localparam int unsigned PIX_LIMIT_W     = 25;

   // channel and pixel widths
   localparam int unsigned CHAN_W   = 8;
   localparam logic [7:0]  HITS_MAX = 8'd255;

   // shared multiply-add operand widths
   localparam int unsigned MAC_A_W = 24;
   localparam int unsigned MAC_B_W = 16;
   localparam int unsigned NUM_W   = 32;

   // divider widths: the blend quotient never exceeds one channel
   localparam int unsigned DEN_W  = 25;
   localparam int unsigned QUOT_W = 8;

   typedef enum logic {
      OP_SPLAT = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef struct packed {
      logic [CHAN_W-1:0] hits;
      logic [CHAN_W-1:0] coverage;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic               en;
      logic [MAC_A_W-1:0] a;
      logic [MAC_B_W-1:0] b;
      logic [NUM_W-1:0]   c;
   } mac_op_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_stat_type;

endpackage

// ----- rtl/core/csbd_if.sv -----
// request and response channel interfaces for the splat blend
// depends on csbd_pkg
interface csbd_req_if;
   logic                            valid;
   logic                            ready;
   logic                            op;
   logic [csbd_pkg::INDEX_W-1:0]    pixel_index;
   logic [csbd_pkg::CHAN_W-1:0]     brush_weight;
   logic [csbd_pkg::CHAN_W-1:0]     red_in;
   logic [csbd_pkg::CHAN_W-1:0]     green_in;
   logic [csbd_pkg::CHAN_W-1:0]     blue_in;

   modport source (output valid, op, pixel_index, brush_weight, red_in, green_in, blue_in,
                   input ready);
   modport sink (input valid, op, pixel_index, brush_weight, red_in, green_in, blue_in,
                 output ready);
endinterface

interface csbd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        updated;
   logic [csbd_pkg::CHAN_W-1:0] coverage_out;
   logic [csbd_pkg::CHAN_W-1:0] hits_out;
   logic [csbd_pkg::CHAN_W-1:0] red_out;
   logic [csbd_pkg::CHAN_W-1:0] green_out;
   logic [csbd_pkg::CHAN_W-1:0] blue_out;

   modport source (output valid, updated, coverage_out, hits_out, red_out, green_out, blue_out,
                   input ready);
   modport sink (input valid, updated, coverage_out, hits_out, red_out, green_out, blue_out,
                 output ready);
endinterface

// ----- rtl/core/csbd_mac.sv -----
// shared multiply-add unit: registered a*b+c
// depends on csbd_pkg
module csbd_mac (
   input  logic                        clock,
   input  csbd_pkg::mac_op_type        mac_op,
   output logic [csbd_pkg::NUM_W-1:0]  mac_res
);

   logic [csbd_pkg::MAC_A_W+csbd_pkg::MAC_B_W-1:0] prod;
   logic [csbd_pkg::NUM_W-1:0]                     res_ff;
   logic [csbd_pkg::NUM_W-1:0]                     res_in;

   // product and addend, truncated to the working width
   always_comb begin
      prod   = mac_op.a * mac_op.b;
      res_in = prod[csbd_pkg::NUM_W-1:0] + mac_op.c;
   end

   always_ff @(posedge clock) begin
      if (mac_op.en) begin
         res_ff <= res_in;
      end
   end

   assign mac_res = res_ff;

endmodule

// ----- rtl/core/csbd_div.sv -----
// restoring radix-2 divider, one quotient bit per cycle
// depends on csbd_pkg
module csbd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  csbd_pkg::div_req_type  div_req,
   output csbd_pkg::div_stat_type div_stat
);

   localparam int unsigned NUM_W  = csbd_pkg::NUM_W;
   localparam int unsigned QUOT_W = csbd_pkg::QUOT_W;
   localparam int unsigned CNT_W  = $clog2(QUOT_W + 1);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [NUM_W:0]    diff;
   logic              fits;

   // trial subtract of the shifted divisor
   always_comb begin
      diff = {1'b0, rem_ff} - {1'b0, dsh_ff};
      fits = !diff[NUM_W];
   end

   // next state of the iteration
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dsh_in  = NUM_W'(div_req.divisor) << (QUOT_W - 1);
         quot_in = '0;
         cnt_in  = CNT_W'(QUOT_W);
      end else if (cnt_ff != '0) begin
         if (fits) begin
            rem_in = diff[NUM_W-1:0];
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign div_stat.done = done_ff;
   assign div_stat.quot = quot_ff;

endmodule

// ----- rtl/core/csbd_mem.sv -----
// pixel store: one write port, one registered read port
// depends on csbd_pkg
module csbd_mem #(
   parameter int unsigned DEPTH  = csbd_pkg::PIXEL_COUNT_DEF,
   parameter int unsigned ADDR_W = csbd_pkg::INDEX_W
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  csbd_pkg::pixel_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output csbd_pkg::pixel_type rd_data
);

   csbd_pkg::pixel_type mem_ram [DEPTH];
   csbd_pkg::pixel_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/coverage_weighted_splat_blend.sv -----
// coverage weighted splat blend: one item at a time through a shared multiply-add and divider
// the pixel is read in ST_READ and ST_LOAD; a full splat then runs eleven multiply-add steps
// and three divides (red, green, blue); reads and skipped splats go straight to ST_DONE, where
// the result is registered once the output is free; only then is a new item taken
// reset: synchronous; the store is then cleared one entry a cycle, min(PIXEL_COUNT, 65536)
// entries, with req ready low; depends on csbd_pkg, csbd_if, csbd_mac, csbd_div, csbd_mem
module coverage_weighted_splat_blend #(
   parameter int unsigned PIXEL_COUNT = csbd_pkg::PIXEL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   csbd_req_if.sink    req_chan,
   csbd_rsp_if.source  rsp_chan
);

   localparam int unsigned MEM_DEPTH = (PIXEL_COUNT > csbd_pkg::INDEX_SPAN) ?
                                       csbd_pkg::INDEX_SPAN : PIXEL_COUNT;
   localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int unsigned LIM_W     = csbd_pkg::PIX_LIMIT_W;
   localparam int unsigned CW        = csbd_pkg::CHAN_W;
   localparam int unsigned A_W       = csbd_pkg::MAC_A_W;
   localparam int unsigned B_W       = csbd_pkg::MAC_B_W;
   localparam int unsigned NUM_W     = csbd_pkg::NUM_W;
   localparam int unsigned DEN_W     = csbd_pkg::DEN_W;

   // multiply-add step codes; most steps capture or take in the result of the one before
   localparam logic [3:0] MUL_COV   = 4'd0;
   localparam logic [3:0] MUL_OLD   = 4'd1;
   localparam logic [3:0] MUL_PTMP  = 4'd2;
   localparam logic [3:0] MUL_PIX   = 4'd3;
   localparam logic [3:0] MUL_R_OLD = 4'd4;
   localparam logic [3:0] MUL_R_NEW = 4'd5;
   localparam logic [3:0] MUL_G_OLD = 4'd6;
   localparam logic [3:0] MUL_G_NEW = 4'd7;
   localparam logic [3:0] MUL_B_OLD = 4'd8;
   localparam logic [3:0] MUL_B_NEW = 4'd9;
   localparam logic [3:0] MUL_LAST  = 4'd10;

   // channel codes for the divide sequence
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_LOAD  = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [3:0]        step_ff, step_in;
   logic [1:0]        ch_ff, ch_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic                         op_ff, op_in;
   logic [csbd_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [CW-1:0]                mp_ff, mp_in;
   logic [CW-1:0]                new_r_ff, new_r_in;
   logic [CW-1:0]                new_g_ff, new_g_in;
   logic [CW-1:0]                new_b_ff, new_b_in;
   logic                         range_ok_ff, range_ok_in;
   logic                         splat_ff, splat_in;
   csbd_pkg::pixel_type          old_pix_ff, old_pix_in;

   logic [15:0]      mm_ff, mm_in;
   logic [A_W-1:0]   hist_wt_ff, hist_wt_in;
   logic [A_W-1:0]   brush_wt_ff, brush_wt_in;
   logic [NUM_W-1:0] num_ff [3];
   logic [NUM_W-1:0] num_in [3];
   logic [CW-1:0]    blend_ff [3];
   logic [CW-1:0]    blend_in [3];

   logic                updated_ff, updated_in;
   csbd_pkg::pixel_type out_pix_ff, out_pix_in;

   csbd_pkg::mac_op_type   mac_op;
   logic [NUM_W-1:0]       mac_res;
   csbd_pkg::div_req_type  div_req;
   csbd_pkg::div_stat_type div_stat;

   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   csbd_pkg::pixel_type mem_wr_data;
   logic                mem_rd_en;
   csbd_pkg::pixel_type mem_rd_data;

   logic                accept;
   logic                out_free;
   logic                do_splat;
   logic                finish;
   logic [CW-1:0]       hits_next;
   logic [15:0]         scale_arg;
   logic [15:0]         cov_sum;
   logic [8:0]          cov_mix;
   logic [1:0]          div_sel;
   csbd_pkg::pixel_type res_pix;

   // handshakes
   assign accept   = (state_ff == ST_IDLE) && req_chan.valid;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish   = (state_ff == ST_DONE) && out_free;

   // splat decision on the freshly read pixel
   assign do_splat = range_ok_ff && (op_ff == csbd_pkg::OP_SPLAT) &&
                     (mem_rd_data.hits != csbd_pkg::HITS_MAX) && (mp_ff != '0);

   // hit count after the increment and 255*n - weight
   assign hits_next = old_pix_ff.hits + CW'(1);
   assign scale_arg = 16'({hits_next, 8'h00}) - 16'(hits_next) - 16'(mp_ff);

   // new coverage: old + weight - old*weight/255, quotient by add-and-shift
   always_comb begin
      cov_sum = mm_ff + {8'h00, mm_ff[15:8]} + 16'd1;
      cov_mix = 9'(old_pix_ff.coverage) + 9'(mp_ff) - 9'(cov_sum[15:8]);
   end

   // shared multiply-add operand select
   always_comb begin
      mac_op.en = (state_ff == ST_MUL);
      mac_op.a  = '0;
      mac_op.b  = '0;
      mac_op.c  = '0;
      case (step_ff)
         MUL_COV: begin
            mac_op.a = A_W'(old_pix_ff.coverage);
            mac_op.b = B_W'(mp_ff);
         end
         MUL_OLD: begin
            mac_op.a = A_W'(old_pix_ff.coverage);
            mac_op.b = scale_arg;
         end
         MUL_PTMP: begin
            mac_op.a = A_W'(CW'(8'd255) - old_pix_ff.coverage);
            mac_op.b = B_W'(hits_next);
            mac_op.c = NUM_W'(old_pix_ff.coverage);
         end
         MUL_PIX: begin
            mac_op.a = A_W'(mp_ff);
            mac_op.b = mac_res[B_W-1:0];
         end
         MUL_R_OLD: begin
            mac_op.a = hist_wt_ff;
            mac_op.b = B_W'(old_pix_ff.red);
         end
         MUL_R_NEW: begin
            mac_op.a = brush_wt_ff;
            mac_op.b = B_W'(new_r_ff);
            mac_op.c = mac_res;
         end
         MUL_G_OLD: begin
            mac_op.a = hist_wt_ff;
            mac_op.b = B_W'(old_pix_ff.green);
         end
         MUL_G_NEW: begin
            mac_op.a = brush_wt_ff;
            mac_op.b = B_W'(new_g_ff);
            mac_op.c = mac_res;
         end
         MUL_B_OLD: begin
            mac_op.a = hist_wt_ff;
            mac_op.b = B_W'(old_pix_ff.blue);
         end
         MUL_B_NEW: begin
            mac_op.a = brush_wt_ff;
            mac_op.b = B_W'(new_b_ff);
            mac_op.c = mac_res;
         end
         default: begin
            mac_op.a = '0;
         end
      endcase
   end

   // divider launch: red after the last multiply, then each following channel
   always_comb begin
      div_sel = (state_ff == ST_MUL) ? CH_RED : ch_ff + 2'd1;
      div_req.start   = ((state_ff == ST_MUL) && (step_ff == MUL_LAST)) ||
                        ((state_ff == ST_DIV) && div_stat.done && (ch_ff != CH_BLUE));
      div_req.divisor = DEN_W'(hist_wt_ff) + DEN_W'(brush_wt_ff);
      case (div_sel)
         CH_RED:   div_req.dividend = num_ff[0];
         CH_GREEN: div_req.dividend = num_ff[1];
         default:  div_req.dividend = num_ff[2];
      endcase
   end

   // result pixel
   always_comb begin
      if (!range_ok_ff) begin
         res_pix = '0;
      end else if (splat_ff) begin
         res_pix.hits     = hits_next;
         res_pix.coverage = cov_mix[CW-1:0];
         res_pix.red      = blend_ff[0];
         res_pix.green    = blend_ff[1];
         res_pix.blue     = blend_ff[2];
      end else begin
         res_pix = old_pix_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      step_in     = step_ff;
      ch_in       = ch_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            step_in  = MUL_COV;
            state_in = do_splat ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            step_in = step_ff + 4'd1;
            if (step_ff == MUL_LAST) begin
               ch_in    = CH_RED;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               ch_in = ch_ff + 2'd1;
               if (ch_ff == CH_BLUE) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // item capture, pixel load and multiply-add captures
   always_comb begin
      op_in        = op_ff;
      idx_in       = idx_ff;
      mp_in        = mp_ff;
      new_r_in     = new_r_ff;
      new_g_in     = new_g_ff;
      new_b_in     = new_b_ff;
      range_ok_in  = range_ok_ff;
      splat_in     = splat_ff;
      old_pix_in   = old_pix_ff;
      mm_in        = mm_ff;
      hist_wt_in   = hist_wt_ff;
      brush_wt_in  = brush_wt_ff;
      num_in       = num_ff;
      blend_in     = blend_ff;
      if (accept) begin
         op_in       = req_chan.op;
         idx_in      = req_chan.pixel_index;
         mp_in       = req_chan.brush_weight;
         new_r_in    = req_chan.red_in;
         new_g_in    = req_chan.green_in;
         new_b_in    = req_chan.blue_in;
         range_ok_in = LIM_W'(req_chan.pixel_index) < LIM_W'(PIXEL_COUNT);
      end
      if (state_ff == ST_LOAD) begin
         old_pix_in = mem_rd_data;
         splat_in   = do_splat;
      end
      if (state_ff == ST_MUL) begin
         if (step_ff == MUL_OLD) begin
            mm_in = mac_res[15:0];
         end
         if (step_ff == MUL_PTMP) begin
            hist_wt_in = mac_res[A_W-1:0];
         end
         if (step_ff == MUL_R_OLD) begin
            brush_wt_in = mac_res[A_W-1:0];
         end
         if (step_ff == MUL_G_OLD) begin
            num_in[0] = mac_res;
         end
         if (step_ff == MUL_B_OLD) begin
            num_in[1] = mac_res;
         end
         if (step_ff == MUL_LAST) begin
            num_in[2] = mac_res;
         end
      end
      if ((state_ff == ST_DIV) && div_stat.done) begin
         case (ch_ff)
            CH_RED:   blend_in[0] = div_stat.quot;
            CH_GREEN: blend_in[1] = div_stat.quot;
            default:  blend_in[2] = div_stat.quot;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      updated_in   = updated_ff;
      out_pix_in   = out_pix_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         updated_in   = splat_ff;
         out_pix_in   = res_pix;
      end
   end

   // store ports: clearing pass, then write-back of splats
   always_comb begin
      mem_rd_en = (state_ff == ST_READ);
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = finish && splat_ff;
         mem_wr_addr = idx_ff[ADDR_W-1:0];
         mem_wr_data = res_pix;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         step_ff      <= MUL_COV;
         ch_ff        <= CH_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         step_ff      <= step_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      mp_ff        <= mp_in;
      new_r_ff     <= new_r_in;
      new_g_ff     <= new_g_in;
      new_b_ff     <= new_b_in;
      range_ok_ff  <= range_ok_in;
      splat_ff     <= splat_in;
      old_pix_ff   <= old_pix_in;
      mm_ff        <= mm_in;
      hist_wt_ff   <= hist_wt_in;
      brush_wt_ff  <= brush_wt_in;
      num_ff       <= num_in;
      blend_ff     <= blend_in;
      updated_ff   <= updated_in;
      out_pix_ff   <= out_pix_in;
   end

   csbd_mac u_mac (
      .clock   (clock),
      .mac_op  (mac_op),
      .mac_res (mac_res)
   );

   csbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat)
   );

   csbd_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   // port drive
   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.updated      = updated_ff;
   assign rsp_chan.coverage_out = out_pix_ff.coverage;
   assign rsp_chan.hits_out     = out_pix_ff.hits;
   assign rsp_chan.red_out      = out_pix_ff.red;
   assign rsp_chan.green_out    = out_pix_ff.green;
   assign rsp_chan.blue_out     = out_pix_ff.blue;

endmodule

// ----- rtl/core/csbd_checker.sv -----
// port-level checker for the splat blend, bound to the top level
// depends on csbd_pkg and coverage_weighted_splat_blend_macros.svh
`include "coverage_weighted_splat_blend_macros.svh"

module csbd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_updated,
   input logic [csbd_pkg::CHAN_W-1:0] rsp_coverage_out,
   input logic [csbd_pkg::CHAN_W-1:0] rsp_hits_out
);

   // one item in flight: ready drops right after an accept
   `CSBD_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "item accepted while busy")

   // an updated pixel has been hit at least once
   `CSBD_ASSERT_NOW(a_upd_hits, clock, reset, rsp_valid && rsp_updated, rsp_hits_out != '0, "updated pixel with zero hits")

   // a merged sample never leaves zero coverage
   `CSBD_ASSERT_NOW(a_upd_cov, clock, reset, rsp_valid && rsp_updated, rsp_coverage_out != '0, "updated pixel with zero coverage")

   // stalled result holds
   `CSBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hits_out), "stalled result dropped or changed")

endmodule

bind coverage_weighted_splat_blend csbd_checker u_csbd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_updated      (rsp_chan.updated),
   .rsp_coverage_out (rsp_chan.coverage_out),
   .rsp_hits_out     (rsp_chan.hits_out)
);

// ----- test/splat_blend_checker.sv -----
// checker for the coverage weighted splat blend: watches both channels, predicts each
// result from its own copy of the pixel store and compares field by field
// depends on csbd_pkg and csbd_if
`timescale 1ns / 100ps

module splat_blend_checker #(
   parameter int unsigned PIXEL_COUNT = csbd_pkg::PIXEL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   csbd_req_if         req_mon,
   csbd_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   import csbd_pkg::*;

   typedef struct packed {
      logic              updated;
      logic [CHAN_W-1:0] coverage;
      logic [CHAN_W-1:0] hits;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_result_type;

   // model copy of the pixel store, untouched entries read as zero
   pixel_type        pixel_store [int unsigned];
   pixel_result_type pixel_result_q [$];
   int unsigned      mismatch_total = 0;

   assign fail_count = mismatch_total;

   // weighted average of one color channel, truncating
   function automatic logic [CHAN_W-1:0] mix_channel(input logic [31:0] hist_wt,
                                                     input logic [31:0] brush_wt,
                                                     input logic [CHAN_W-1:0] old_c,
                                                     input logic [CHAN_W-1:0] new_c);
      logic [63:0] num;
      logic [63:0] den;
      num = 64'(hist_wt) * 64'(old_c) + 64'(brush_wt) * 64'(new_c);
      den = 64'(hist_wt) + 64'(brush_wt);
      if (den == 0) return old_c;
      return CHAN_W'(num / den);
   endfunction

   // apply one item to the model store and return the pixel it reports
   function automatic pixel_result_type blend_pixel(input op_type op,
                                                    input logic [INDEX_W-1:0] pix_idx,
                                                    input logic [CHAN_W-1:0] weight,
                                                    input logic [CHAN_W-1:0] red_new,
                                                    input logic [CHAN_W-1:0] green_new,
                                                    input logic [CHAN_W-1:0] blue_new);
      pixel_type        px;
      pixel_result_type res;
      logic [31:0]      n;
      logic [31:0]      mo;
      logic [31:0]      mp;
      logic [31:0]      hist_wt;
      logic [31:0]      brush_wt;
      res = '0;
      // address past the store: ignored, all fields zero
      if (32'(pix_idx) >= PIXEL_COUNT) return res;
      px = pixel_store.exists(32'(pix_idx)) ? pixel_store[32'(pix_idx)] : '0;
      // splat only when the pixel is not saturated and the brush has weight
      if (op == OP_SPLAT && px.hits != HITS_MAX && weight != 0) begin
         n         = 32'(px.hits) + 32'd1;
         mo        = 32'(px.coverage);
         mp        = 32'(weight);
         hist_wt   = mo * (32'd255 * n - mp);
         brush_wt  = mp * ((32'd255 - mo) * n + mo);
         px.red      = mix_channel(hist_wt, brush_wt, px.red, red_new);
         px.green    = mix_channel(hist_wt, brush_wt, px.green, green_new);
         px.blue     = mix_channel(hist_wt, brush_wt, px.blue, blue_new);
         px.coverage = CHAN_W'(mo + mp - (mo * mp) / 32'd255);
         px.hits     = CHAN_W'(n);
         pixel_store[32'(pix_idx)] = px;
         res.updated = 1'b1;
      end
      res.coverage = px.coverage;
      res.hits     = px.hits;
      res.red      = px.red;
      res.green    = px.green;
      res.blue     = px.blue;
      return res;
   endfunction

   task automatic note_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
      mismatch_total++;
      if (mismatch_total <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
   endtask

   // results are checked before new items are queued: a result always belongs to an older item
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pixel_result_q.size() == 0) begin
               note_mismatch("unexpected result, hits_out", 0, rsp_mon.hits_out);
            end else begin
               want = pixel_result_q.pop_front();
               if (rsp_mon.updated !== want.updated)
                  note_mismatch("updated", want.updated, rsp_mon.updated);
               if (rsp_mon.coverage_out !== want.coverage)
                  note_mismatch("coverage_out", want.coverage, rsp_mon.coverage_out);
               if (rsp_mon.hits_out !== want.hits)
                  note_mismatch("hits_out", want.hits, rsp_mon.hits_out);
               if (rsp_mon.red_out !== want.red)
                  note_mismatch("red_out", want.red, rsp_mon.red_out);
               if (rsp_mon.green_out !== want.green)
                  note_mismatch("green_out", want.green, rsp_mon.green_out);
               if (rsp_mon.blue_out !== want.blue)
                  note_mismatch("blue_out", want.blue, rsp_mon.blue_out);
            end
         end
         if (req_mon.valid && req_mon.ready)
            pixel_result_q.push_back(blend_pixel(op_type'(req_mon.op), req_mon.pixel_index,
                                                 req_mon.brush_weight, req_mon.red_in,
                                                 req_mon.green_in, req_mon.blue_in));
         pending_count <= pixel_result_q.size();
      end
   end

endmodule

// ----- test/testbench.sv -----
// top of the splat blend regression: clock, reset, item stimulus and the verdict
// depends on csbd_pkg, csbd_if, coverage_weighted_splat_blend and splat_blend_checker
`timescale 1ns / 100ps

module testbench;

   import csbd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned RANDOM_ITEMS = 650;
   localparam int unsigned DRAIN_CYCLES = 60;

   logic        clock;
   logic        reset;
   bit          steady = 1'b0;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;

   csbd_req_if req_bus ();
   csbd_rsp_if rsp_bus ();

   coverage_weighted_splat_blend u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   splat_blend_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("coverage_weighted_splat_blend regression: fail");
      $finish;
   end

   // result side: random stall before each item, none in steady stretches
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // present one item after a random gap and hold it until accepted
   task automatic send_item(input op_type op, input logic [INDEX_W-1:0] pix_idx,
                            input logic [CHAN_W-1:0] weight, input logic [CHAN_W-1:0] red,
                            input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.pixel_index  <= pix_idx;
      req_bus.brush_weight <= weight;
      req_bus.red_in       <= red;
      req_bus.green_in     <= green;
      req_bus.blue_in      <= blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // stop sending until every result is back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      logic [INDEX_W-1:0] hot_pixel;
      logic [INDEX_W-1:0] pixel_pool [8];
      logic [INDEX_W-1:0] pix_idx;
      logic [CHAN_W-1:0]  weight;
      op_type             op;
      int unsigned        pick;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.op           <= OP_SPLAT;
      req_bus.pixel_index  <= '0;
      req_bus.brush_weight <= '0;
      req_bus.red_in       <= '0;
      req_bus.green_in     <= '0;
      req_bus.blue_in      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: untouched pixels, weight extremes, skipped splats, reads
      send_item(OP_READ,  16'h0000, 8'd0,   8'd0,   8'd0,   8'd0);
      send_item(OP_READ,  16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255);
      send_item(OP_SPLAT, 16'h0000, 8'd255, 8'd255, 8'd255, 8'd255);
      send_item(OP_READ,  16'h0000, 8'd0,   8'd0,   8'd0,   8'd0);
      send_item(OP_SPLAT, 16'h0000, 8'd0,   8'd12,  8'd34,  8'd56);
      send_item(OP_SPLAT, 16'h0000, 8'd1,   8'd0,   8'd0,   8'd0);
      send_item(OP_SPLAT, 16'h0000, 8'd255, 8'd0,   8'd0,   8'd0);
      send_item(OP_SPLAT, 16'hFFFF, 8'd1,   8'd255, 8'd0,   8'd128);
      send_item(OP_SPLAT, 16'hFFFF, 8'd255, 8'd0,   8'd255, 8'd1);
      send_item(OP_SPLAT, 16'hFFFF, 8'd128, 8'd127, 8'd128, 8'd254);
      send_item(OP_SPLAT, 16'h5555, 8'd128, 8'hAA,  8'hAA,  8'hAA);
      send_item(OP_SPLAT, 16'hAAAA, 8'd127, 8'h55,  8'h55,  8'h55);
      send_item(OP_SPLAT, 16'h5555, 8'd2,   8'h55,  8'h0F,  8'hF0);
      send_item(OP_READ,  16'h5555, 8'd200, 8'd1,   8'd2,   8'd3);
      send_item(OP_SPLAT, 16'hAAAA, 8'd0,   8'd255, 8'd255, 8'd255);
      send_item(OP_READ,  16'hAAAA, 8'd0,   8'd0,   8'd0,   8'd0);
      send_item(OP_SPLAT, 16'h0001, 8'd254, 8'd200, 8'd100, 8'd50);
      send_item(OP_SPLAT, 16'h8000, 8'd64,  8'd17,  8'd34,  8'd68);
      send_item(OP_READ,  16'hFFFF, 8'd0,   8'd0,   8'd0,   8'd0);
      wait_drained();

      // random: a hot pixel takes enough splats to saturate, a small pool
      // builds up deeper histories, the rest spread over the whole store
      hot_pixel = 16'($urandom);
      foreach (pixel_pool[k]) pixel_pool[k] = 16'($urandom);
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         steady = ((i / 60) % 4) == 3;
         pick = $urandom_range(0, 99);
         if (pick < 60)
            pix_idx = hot_pixel;
         else if (pick < 80)
            pix_idx = pixel_pool[$urandom_range(0, 7)];
         else
            pix_idx = 16'($urandom);
         op = ($urandom_range(0, 99) < 15) ? OP_READ : OP_SPLAT;
         pick = $urandom_range(0, 99);
         if (pick < 6)
            weight = 8'd0;
         else if (pick < 14)
            weight = 8'd255;
         else if (pick < 20)
            weight = 8'd1;
         else
            weight = 8'($urandom_range(0, 255));
         send_item(op, pix_idx, weight, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         if (i % 150 == 149) wait_drained();
      end
      steady = 1'b0;

      // let the last results come back, then watch for strays
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("coverage_weighted_splat_blend regression: pass");
      else
         $display("coverage_weighted_splat_blend regression: fail");
      $finish;
   end

endmodule
